// ===== rtl/core/jlex_pkg.sv =====
// types, codes and byte classification helpers for the json lexer with comments
package jlex_pkg;

  localparam int LEN_W    = 16;
  localparam int KIND_W   = 4;
  localparam int MODE_W   = 4;
  localparam int FIFO_AW  = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // lexer modes
  localparam logic [MODE_W-1:0] M_IDLE   = 4'd0;
  localparam logic [MODE_W-1:0] M_SPACE  = 4'd1;
  localparam logic [MODE_W-1:0] M_CR     = 4'd2;
  localparam logic [MODE_W-1:0] M_VALUE  = 4'd3;
  localparam logic [MODE_W-1:0] M_SLASH  = 4'd4;
  localparam logic [MODE_W-1:0] M_BADVAL = 4'd5;
  localparam logic [MODE_W-1:0] M_LINE   = 4'd6;
  localparam logic [MODE_W-1:0] M_BLOCKC = 4'd7;
  localparam logic [MODE_W-1:0] M_Q1     = 4'd8;
  localparam logic [MODE_W-1:0] M_Q2     = 4'd9;
  localparam logic [MODE_W-1:0] M_STR    = 4'd10;
  localparam logic [MODE_W-1:0] M_BSTR   = 4'd11;

  // token kinds
  localparam logic [KIND_W-1:0] K_SPACE    = 4'd0;
  localparam logic [KIND_W-1:0] K_NEWLINE  = 4'd1;
  localparam logic [KIND_W-1:0] K_LBRACKET = 4'd2;
  localparam logic [KIND_W-1:0] K_RBRACKET = 4'd3;
  localparam logic [KIND_W-1:0] K_LBRACE   = 4'd4;
  localparam logic [KIND_W-1:0] K_RBRACE   = 4'd5;
  localparam logic [KIND_W-1:0] K_COLON    = 4'd6;
  localparam logic [KIND_W-1:0] K_COMMA    = 4'd7;
  localparam logic [KIND_W-1:0] K_VALUE    = 4'd8;
  localparam logic [KIND_W-1:0] K_STRING   = 4'd9;
  localparam logic [KIND_W-1:0] K_BSTRING  = 4'd10;
  localparam logic [KIND_W-1:0] K_COMMENT  = 4'd11;
  localparam logic [KIND_W-1:0] K_BCOMMENT = 4'd12;
  localparam logic [KIND_W-1:0] K_INVALID  = 4'd13;

  // byte codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [1:0] QRUN_FULL = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  len;
    logic              esc;
    logic [1:0]        qrun;
    logic              pm;
    logic              clean;
  } lex_state_t;

  typedef struct packed {
    lex_state_t        state;
    logic              emit;
    logic [KIND_W-1:0] kind;
  } start_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  len;
    logic              last;
  } res_t;

  function automatic lex_state_t idle_state();
    lex_state_t s;
    s.mode  = M_IDLE;
    s.len   = '0;
    s.esc   = 1'b0;
    s.qrun  = 2'd0;
    s.pm    = 1'b0;
    s.clean = 1'b1;
    return s;
  endfunction

  function automatic logic [LEN_W-1:0] grow_len(input logic [LEN_W-1:0] len);
    return (len == LEN_MAX) ? len : len + LEN_W'(1);
  endfunction

  function automatic logic is_delim(input logic [7:0] b);
    return (b == CH_TAB) || (b == CH_LF) || (b == CH_CR) || (b == CH_SPACE) ||
           (b == CH_QUOTE) || (b == CH_COMMA) || (b == CH_COLON) ||
           (b == CH_LBRACK) || (b == CH_RBRACK) || (b == CH_LBRACE) ||
           (b == CH_RBRACE);
  endfunction

  // first byte of a token from idle
  function automatic start_t lex_start(input logic [7:0] b);
    start_t r;
    r.state = idle_state();
    r.emit  = 1'b0;
    r.kind  = K_INVALID;
    unique case (b)
      CH_SPACE, CH_TAB: begin r.state.mode = M_SPACE; r.state.len = LEN_W'(1); end
      CH_CR:     begin r.state.mode = M_CR;    r.state.len = LEN_W'(1); end
      CH_QUOTE:  begin r.state.mode = M_Q1;    r.state.len = LEN_W'(1); end
      CH_SLASH:  begin r.state.mode = M_SLASH; r.state.len = LEN_W'(1); end
      CH_LF:     begin r.emit = 1'b1; r.kind = K_NEWLINE;  end
      CH_LBRACK: begin r.emit = 1'b1; r.kind = K_LBRACKET; end
      CH_RBRACK: begin r.emit = 1'b1; r.kind = K_RBRACKET; end
      CH_LBRACE: begin r.emit = 1'b1; r.kind = K_LBRACE;   end
      CH_RBRACE: begin r.emit = 1'b1; r.kind = K_RBRACE;   end
      CH_COLON:  begin r.emit = 1'b1; r.kind = K_COLON;    end
      CH_COMMA:  begin r.emit = 1'b1; r.kind = K_COMMA;    end
      default:   begin r.state.mode = M_VALUE; r.state.len = LEN_W'(1); end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/json_lexer_with_comments_top.sv =====
// top level of the streaming json lexer with comments and block strings
//
// usage
//   input channel: in_text_byte and in_final_byte, one byte per transaction,
//   handshake in_valid / in_stall. in_final_byte marks the last byte of the
//   text; any token still open is flushed after that byte and the lexer idles.
//   result channel: out_token_kind, out_token_length, out_last_of_run, one
//   token per transaction, handshake out_valid / out_stall. out_last_of_run
//   marks the last token that a given byte produced. a byte produces zero,
//   one or two tokens.
//   path: the byte is registered at acceptance, lexed from the input register
//   into a four entry result queue, and its first token is shown at the
//   queue head.
//   throughput: one byte per cycle while the input register advances;
//   a byte that yields two tokens takes two transactions of the result port.
//   stall: out_stall holds the queue head; once the queue holds more than
//   two tokens the input register stops advancing and in_stall rises.
//   reset: synchronous, active low; clears the lexer state to idle, the
//   input register and the result queue. no clearing pass is needed.
module json_lexer_with_comments_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_text_byte,
  input  logic                        in_final_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [jlex_pkg::KIND_W-1:0] out_token_kind,
  output logic [15:0]                 out_token_length,
  output logic                        out_last_of_run
);

  logic                         v1_r;
  logic [7:0]                   byte_r;
  logic                         fin_r;
  jlex_pkg::lex_state_t         state_r;
  jlex_pkg::lex_state_t         state_nxt;
  jlex_pkg::res_t               fifo_r [jlex_pkg::FIFO_DEPTH];
  logic [jlex_pkg::FIFO_AW-1:0] wr_ptr_r;
  logic [jlex_pkg::FIFO_AW-1:0] rd_ptr_r;
  logic [jlex_pkg::FIFO_AW:0]   cnt_r;

  logic                         adv;
  logic                         in_acc;
  logic                         out_acc;
  jlex_pkg::start_t             st;
  logic [jlex_pkg::LEN_W-1:0]   g;
  logic                         do_close;
  logic                         do_restart;
  logic [jlex_pkg::KIND_W-1:0]  close_kind;
  logic                         d_emit;
  logic [jlex_pkg::KIND_W-1:0]  d_kind;
  logic [jlex_pkg::KIND_W-1:0]  flush_kind;
  logic                         a_v;
  logic                         b_v;
  logic                         s_v;
  jlex_pkg::res_t               a_res;
  jlex_pkg::res_t               b_res;
  jlex_pkg::res_t               e0;
  jlex_pkg::res_t               e1;
  logic [1:0]                   n_push;

  assign adv      = v1_r && (cnt_r <= (jlex_pkg::FIFO_AW+1)'(jlex_pkg::FIFO_DEPTH - 2));
  assign in_stall = v1_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (cnt_r != '0);
  assign out_acc  = out_valid && !out_stall;

  // per-byte lexer update
  always_comb begin
    state_nxt  = state_r;
    st         = jlex_pkg::lex_start(byte_r);
    g          = jlex_pkg::grow_len(state_r.len);
    do_close   = 1'b0;
    do_restart = 1'b0;
    close_kind = jlex_pkg::K_INVALID;
    d_emit     = 1'b0;
    d_kind     = jlex_pkg::K_INVALID;
    unique case (state_r.mode)
      jlex_pkg::M_IDLE: begin
        do_restart = 1'b1;
      end
      jlex_pkg::M_SPACE: begin
        if (byte_r == jlex_pkg::CH_SPACE || byte_r == jlex_pkg::CH_TAB) begin
          state_nxt.len = g;
        end else begin
          do_close   = 1'b1;
          close_kind = jlex_pkg::K_SPACE;
        end
      end
      jlex_pkg::M_CR: begin
        if (byte_r == jlex_pkg::CH_LF) begin
          d_emit    = 1'b1;
          d_kind    = jlex_pkg::K_NEWLINE;
          state_nxt = jlex_pkg::idle_state();
        end else begin
          do_close   = 1'b1;
          close_kind = jlex_pkg::K_NEWLINE;
        end
      end
      jlex_pkg::M_VALUE, jlex_pkg::M_BADVAL: begin
        if (jlex_pkg::is_delim(byte_r)) begin
          do_close   = 1'b1;
          close_kind = (state_r.mode == jlex_pkg::M_VALUE) ? jlex_pkg::K_VALUE
                                                          : jlex_pkg::K_INVALID;
        end else begin
          state_nxt.len = g;
        end
      end
      jlex_pkg::M_SLASH: begin
        if (byte_r == jlex_pkg::CH_SLASH) begin
          state_nxt.mode = jlex_pkg::M_LINE;
          state_nxt.len  = g;
        end else if (byte_r == jlex_pkg::CH_STAR) begin
          state_nxt.mode = jlex_pkg::M_BLOCKC;
          state_nxt.pm   = 1'b0;
          state_nxt.len  = g;
        end else if (jlex_pkg::is_delim(byte_r)) begin
          do_close   = 1'b1;
          close_kind = jlex_pkg::K_INVALID;
        end else begin
          state_nxt.mode = jlex_pkg::M_BADVAL;
          state_nxt.len  = g;
        end
      end
      jlex_pkg::M_LINE: begin
        if (byte_r == jlex_pkg::CH_CR || byte_r == jlex_pkg::CH_LF) begin
          do_close   = 1'b1;
          close_kind = jlex_pkg::K_COMMENT;
        end else begin
          state_nxt.len = g;
        end
      end
      jlex_pkg::M_BLOCKC: begin
        state_nxt.len = g;
        if (byte_r == jlex_pkg::CH_SLASH && state_r.pm) begin
          d_emit    = 1'b1;
          d_kind    = jlex_pkg::K_BCOMMENT;
          state_nxt = jlex_pkg::idle_state();
        end else begin
          state_nxt.pm = (byte_r == jlex_pkg::CH_STAR);
        end
      end
      jlex_pkg::M_Q1, jlex_pkg::M_STR: begin
        if (state_r.mode == jlex_pkg::M_Q1) begin
          state_nxt.clean = 1'b1;
          state_nxt.esc   = 1'b0;
        end
        if (state_r.mode == jlex_pkg::M_Q1 && byte_r == jlex_pkg::CH_QUOTE) begin
          state_nxt.mode = jlex_pkg::M_Q2;
          state_nxt.len  = g;
        end else begin
          state_nxt.mode = jlex_pkg::M_STR;
          if (byte_r < jlex_pkg::CH_SPACE) begin
            if (byte_r == jlex_pkg::CH_LF) begin
              do_close   = 1'b1;
              close_kind = jlex_pkg::K_INVALID;
            end else begin
              state_nxt.len   = g;
              state_nxt.clean = 1'b0;
            end
          end else if (state_nxt.esc) begin
            state_nxt.esc = 1'b0;
            state_nxt.len = g;
          end else if (byte_r == jlex_pkg::CH_QUOTE) begin
            d_emit    = 1'b1;
            d_kind    = state_nxt.clean ? jlex_pkg::K_STRING : jlex_pkg::K_INVALID;
            state_nxt = jlex_pkg::idle_state();
          end else begin
            state_nxt.esc = (byte_r == jlex_pkg::CH_BSLASH);
            state_nxt.len = g;
          end
        end
      end
      jlex_pkg::M_Q2: begin
        if (byte_r == jlex_pkg::CH_QUOTE) begin
          state_nxt.mode = jlex_pkg::M_BSTR;
          state_nxt.qrun = 2'd0;
          state_nxt.len  = g;
        end else begin
          do_close   = 1'b1;
          close_kind = jlex_pkg::K_STRING;
        end
      end
      jlex_pkg::M_BSTR: begin
        if (byte_r == jlex_pkg::CH_QUOTE) begin
          state_nxt.len = g;
          if (state_r.qrun != jlex_pkg::QRUN_FULL) begin
            state_nxt.qrun = state_r.qrun + 2'd1;
          end
        end else if (state_r.qrun != jlex_pkg::QRUN_FULL) begin
          state_nxt.qrun = 2'd0;
          state_nxt.len  = g;
        end else begin
          do_close   = 1'b1;
          close_kind = jlex_pkg::K_BSTRING;
        end
      end
      default: begin
        do_restart = 1'b1;
      end
    endcase

    if (do_close || do_restart) begin
      state_nxt = st.state;
    end

    case (state_nxt.mode)
      jlex_pkg::M_SPACE: flush_kind = jlex_pkg::K_SPACE;
      jlex_pkg::M_CR:    flush_kind = jlex_pkg::K_NEWLINE;
      jlex_pkg::M_VALUE: flush_kind = jlex_pkg::K_VALUE;
      jlex_pkg::M_LINE:  flush_kind = jlex_pkg::K_COMMENT;
      jlex_pkg::M_Q2:    flush_kind = jlex_pkg::K_STRING;
      jlex_pkg::M_BSTR:  flush_kind = (state_nxt.qrun == jlex_pkg::QRUN_FULL)
                                      ? jlex_pkg::K_BSTRING : jlex_pkg::K_INVALID;
      default:           flush_kind = jlex_pkg::K_INVALID;
    endcase

    a_v        = do_close || d_emit;
    a_res.kind = do_close ? close_kind : d_kind;
    a_res.len  = do_close ? state_r.len : g;
    a_res.last = 1'b0;

    s_v        = (do_close || do_restart) && st.emit;
    b_v        = s_v || (fin_r && state_nxt.mode != jlex_pkg::M_IDLE);
    b_res.kind = s_v ? st.kind : flush_kind;
    b_res.len  = s_v ? jlex_pkg::LEN_W'(1) : state_nxt.len;
    b_res.last = 1'b1;

    if (fin_r) begin
      state_nxt = jlex_pkg::idle_state();
    end

    e0      = a_v ? a_res : b_res;
    e0.last = !(a_v && b_v);
    e1      = b_res;
    n_push  = {1'b0, a_v} + {1'b0, b_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      state_r  <= jlex_pkg::idle_state();
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_acc) begin
        v1_r <= 1'b1;
      end else if (adv) begin
        v1_r <= 1'b0;
      end
      if (adv) begin
        state_r  <= state_nxt;
        wr_ptr_r <= wr_ptr_r + jlex_pkg::FIFO_AW'(n_push);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + jlex_pkg::FIFO_AW'(1);
      end
      cnt_r <= cnt_r + (adv ? (jlex_pkg::FIFO_AW+1)'(n_push) : '0)
                     - (jlex_pkg::FIFO_AW+1)'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_text_byte;
      fin_r  <= in_final_byte;
    end
    if (adv && n_push != 2'd0) begin
      fifo_r[wr_ptr_r] <= e0;
    end
    if (adv && n_push == 2'd2) begin
      fifo_r[wr_ptr_r + jlex_pkg::FIFO_AW'(1)] <= e1;
    end
  end

  assign out_token_kind   = fifo_r[rd_ptr_r].kind;
  assign out_token_length = fifo_r[rd_ptr_r].len;
  assign out_last_of_run  = fifo_r[rd_ptr_r].last;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (jlex_pkg::FIFO_AW+1)'(jlex_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && fin_r |=> state_r.mode == jlex_pkg::M_IDLE)
    else $error("lexer not idle after final byte");

  a_flush_emits: assert property (@(posedge clk) disable iff (!rst_n)
    adv && fin_r && state_r.mode != jlex_pkg::M_IDLE |-> n_push != 2'd0)
    else $error("open token not flushed on final byte");
`endif

endmodule
